[rtl/core/tilt_estimator_posture_detect_unit_macros.svh]
// Assertion macros shared by the tilt estimator RTL
`ifndef TILT_ESTIMATOR_POSTURE_DETECT_UNIT_MACROS_SVH
`define TILT_ESTIMATOR_POSTURE_DETECT_UNIT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define TEP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication under synchronous active-low reset
`define TEP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/tep_pkg.sv]
// Types, constants and helper functions for the tilt estimator
package tep_pkg;

    typedef logic signed [24:0] t_ang;
    typedef logic signed [18:0] t_cin;
    typedef logic signed [25:0] t_z;
    typedef logic signed [31:0] t_cvec;

    localparam int CORDIC_STEPS = 16;

    localparam t_ang ANG_MAX = 25'sd11796480;
    localparam t_z   Z_DEG90  = 26'sd5898240;
    localparam t_z   Z_DEG180 = 26'sd11796480;

    localparam logic [16:0] ABS_VERTEX_LIM = 17'd2000;
    localparam logic [16:0] ABS_EDGE_LO    = 17'd7000;
    localparam logic [16:0] ABS_EDGE_HI    = 17'd10000;
    localparam logic [23:0] VERT_TILT_LIM  = 24'd26214;
    localparam logic [23:0] EDGE_TILT_LIM  = 24'd19660;
    localparam logic [23:0] FALL_TILT_LIM  = 24'd458752;

    typedef enum logic [1:0] {
        POS_UNKNOWN = 2'd0,
        POS_VERTEX  = 2'd1,
        POS_EDGE    = 2'd2,
        POS_NONE    = 2'd3
    } t_posture;

    typedef enum logic [2:0] {
        CFG_VERTEX_OFF_X = 3'd0,
        CFG_VERTEX_OFF_Y = 3'd1,
        CFG_VERTEX_OFF_Z = 3'd2,
        CFG_EDGE_OFF_X   = 3'd3,
        CFG_EDGE_OFF_Y   = 3'd4,
        CFG_EDGE_OFF_Z   = 3'd5,
        CFG_GYRO_BIAS_X  = 3'd6,
        CFG_GYRO_BIAS_Y  = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_CY_GO,
        ST_CY_WAIT,
        ST_CX_GO,
        ST_CX_WAIT,
        ST_MUL,
        ST_POST,
        ST_DONE
    } t_st;

    typedef enum logic [1:0] {
        COR_IDLE,
        COR_RUN,
        COR_DONE
    } t_cor_st;

    typedef struct packed {
        logic start;
        t_cin y;
        t_cin x;
    } t_cor_req;

    typedef struct packed {
        logic done;
        t_ang angle;
    } t_cor_rsp;

    function automatic t_z atan_tab(input logic [3:0] i);
        t_z r;
        case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117304;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    function automatic t_ang sat_ang(input logic signed [43:0] v);
        t_ang r;
        if (v > 44'(ANG_MAX)) begin
            r = ANG_MAX;
        end else if (v < -44'(ANG_MAX)) begin
            r = -ANG_MAX;
        end else begin
            r = v[24:0];
        end
        return r;
    endfunction

    function automatic logic [23:0] ang_abs(input t_ang v);
        t_ang a;
        a = (v < 0) ? -v : v;
        return a[23:0];
    endfunction

    function automatic logic signed [16:0] out_ang(input t_ang v);
        logic signed [25:0] t;
        t = 26'(v) + 26'sd128;
        return t[24:8];
    endfunction

endpackage

[rtl/core/tep_cordic.sv]
// Iterative vectoring CORDIC computing atan2 in 1/65536 degree
module tep_cordic (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tep_pkg::t_cor_req   i_req,
    output tep_pkg::t_cor_rsp   o_rsp
);

    tep_pkg::t_cor_st r_state, n_state;
    tep_pkg::t_cvec   r_x, r_y;
    tep_pkg::t_z      r_z;
    logic [3:0]       r_i;

    tep_pkg::t_cvec   x_ext, y_ext, dx, dy;

    assign x_ext = 32'(i_req.x);
    assign y_ext = 32'(i_req.y);
    assign dx    = r_y >>> r_i;
    assign dy    = r_x >>> r_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tep_pkg::COR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tep_pkg::COR_IDLE: begin
                if (i_req.start) begin
                    if (i_req.y == 0 || i_req.x == 0) begin
                        n_state = tep_pkg::COR_DONE;
                    end else begin
                        n_state = tep_pkg::COR_RUN;
                    end
                end
            end
            tep_pkg::COR_RUN: begin
                if (r_i == 4'(tep_pkg::CORDIC_STEPS - 1)) begin
                    n_state = tep_pkg::COR_DONE;
                end
            end
            tep_pkg::COR_DONE: n_state = tep_pkg::COR_IDLE;
            default:           n_state = tep_pkg::COR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            tep_pkg::COR_IDLE: begin
                r_i <= '0;
                if (i_req.y == 0) begin
                    r_z <= (i_req.x < 0) ? tep_pkg::Z_DEG180 : '0;
                end else if (i_req.x == 0) begin
                    r_z <= (i_req.y > 0) ? tep_pkg::Z_DEG90 : -tep_pkg::Z_DEG90;
                end else if (i_req.x < 0) begin
                    r_z <= (i_req.y > 0) ? tep_pkg::Z_DEG180 : -tep_pkg::Z_DEG180;
                    r_x <= (-x_ext) <<< 8;
                    r_y <= (-y_ext) <<< 8;
                end else begin
                    r_z <= '0;
                    r_x <= x_ext <<< 8;
                    r_y <= y_ext <<< 8;
                end
            end
            tep_pkg::COR_RUN: begin
                r_i <= r_i + 4'd1;
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + tep_pkg::atan_tab(r_i);
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - tep_pkg::atan_tab(r_i);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.done  = (r_state == tep_pkg::COR_DONE);
    assign o_rsp.angle = tep_pkg::sat_ang(44'(r_z));

endmodule

[rtl/core/tilt_estimator_posture_detect_unit.sv]
// Top level of the complementary-filter tilt estimator with posture detection
// A sample runs through these steps from acceptance until its result word is
// loaded into the output register: the sample is corrected and the gyro
// integrated, two atan2 runs follow on the shared 16-step CORDIC unit (shorter
// when an axis is zero), then the shared blend multiplier forms the blend,
// the posture is updated and the result is loaded. The input is ready again
// in the cycle after the result loads; a result waiting at the output holds
// back only the load of the next one.
module tilt_estimator_posture_detect_unit #(
    parameter int GYRO_WEIGHT_Q16  = 65274,
    parameter int SAMPLE_PERIOD_MS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_rate_x,
    input  logic signed [15:0] i_rate_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [16:0] o_tilt_x_out,
    output logic signed [16:0] o_tilt_y_out,
    output logic signed [16:0] o_acc_tilt_x,
    output logic signed [16:0] o_acc_tilt_y,
    output logic [1:0]         o_posture
);

`include "tilt_estimator_posture_detect_unit_macros.svh"

    localparam logic signed [17:0] W_GYRO = 18'(GYRO_WEIGHT_Q16);
    localparam logic signed [17:0] W_ACC  = 18'(65536 - GYRO_WEIGHT_Q16);
    localparam logic signed [31:0] SP     = 32'(SAMPLE_PERIOD_MS);

    logic signed [15:0] r_voff_x, r_voff_y, r_eoff_x, r_eoff_y, r_bias_x, r_bias_y;
    logic signed [16:0] r_voff_z, r_eoff_z;

    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;
    logic signed [16:0] r_cx, r_cy;
    tep_pkg::t_cin      r_ncz;
    logic [16:0]        r_abs_ax;
    tep_pkg::t_ang      r_tilt_x, r_tilt_y, r_acc_x, r_acc_y;
    tep_pkg::t_posture  r_posture;
    logic [1:0]         r_k;
    logic signed [43:0] r_accum;

    tep_pkg::t_st       r_state, n_state;
    logic               r_o_valid;
    logic               load_out;

    tep_pkg::t_cor_req  cor_req;
    tep_pkg::t_cor_rsp  cor_rsp;

    logic [16:0]        abs_ax;
    logic               use_vertex;
    logic signed [15:0] sel_off_x, sel_off_y;
    logic signed [16:0] sel_off_z;
    logic signed [17:0] cz;
    logic signed [31:0] int_x, int_y;
    tep_pkg::t_ang      mul_a;
    logic signed [17:0] mul_b;
    logic signed [42:0] prod;
    logic signed [43:0] sum;
    logic               vert_ok, edge_ok;

    tep_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_voff_x <= '0;
            r_voff_y <= '0;
            r_voff_z <= '0;
            r_eoff_x <= '0;
            r_eoff_y <= '0;
            r_eoff_z <= '0;
            r_bias_x <= '0;
            r_bias_y <= '0;
        end else if (i_cfg_valid) begin
            unique case (tep_pkg::t_cfg_idx'(i_cfg_index))
                tep_pkg::CFG_VERTEX_OFF_X: r_voff_x <= i_cfg_data[15:0];
                tep_pkg::CFG_VERTEX_OFF_Y: r_voff_y <= i_cfg_data[15:0];
                tep_pkg::CFG_VERTEX_OFF_Z: r_voff_z <= i_cfg_data;
                tep_pkg::CFG_EDGE_OFF_X:   r_eoff_x <= i_cfg_data[15:0];
                tep_pkg::CFG_EDGE_OFF_Y:   r_eoff_y <= i_cfg_data[15:0];
                tep_pkg::CFG_EDGE_OFF_Z:   r_eoff_z <= i_cfg_data;
                tep_pkg::CFG_GYRO_BIAS_X:  r_bias_x <= i_cfg_data[15:0];
                tep_pkg::CFG_GYRO_BIAS_Y:  r_bias_y <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // sample correction and gyro integration
    always_comb begin
        abs_ax     = (r_ax < 0) ? 17'(-17'(r_ax)) : 17'(r_ax);
        use_vertex = (abs_ax < tep_pkg::ABS_VERTEX_LIM);
        sel_off_x  = use_vertex ? r_voff_x : r_eoff_x;
        sel_off_y  = use_vertex ? r_voff_y : r_eoff_y;
        sel_off_z  = use_vertex ? r_voff_z : r_eoff_z;
        cz         = 18'(r_az) - 18'(sel_off_z);
        int_x      = 32'(r_tilt_x) + (32'(17'(r_gx) - 17'(r_bias_x)) * SP);
        int_y      = 32'(r_tilt_y) + (32'(17'(r_gy) - 17'(r_bias_y)) * SP);
    end

    // shared blend multiplier
    always_comb begin
        case (r_k)
            2'd0:    mul_a = r_tilt_y;
            2'd1:    mul_a = r_acc_y;
            2'd2:    mul_a = r_tilt_x;
            default: mul_a = r_acc_x;
        endcase
        mul_b = r_k[0] ? W_ACC : W_GYRO;
        prod  = 43'(mul_a) * 43'(mul_b);
        sum   = r_k[0] ? (r_accum + 44'(prod)) : (44'(prod) + 44'sd32768);
    end

    always_comb begin
        vert_ok = (r_abs_ax < tep_pkg::ABS_VERTEX_LIM)
                  && (tep_pkg::ang_abs(r_acc_x) <= tep_pkg::VERT_TILT_LIM)
                  && (tep_pkg::ang_abs(r_acc_y) <= tep_pkg::VERT_TILT_LIM);
        edge_ok = (r_abs_ax > tep_pkg::ABS_EDGE_LO) && (r_abs_ax < tep_pkg::ABS_EDGE_HI)
                  && (tep_pkg::ang_abs(r_acc_x) <= tep_pkg::EDGE_TILT_LIM);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tep_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        load_out        = 1'b0;
        cor_req.start   = 1'b0;
        cor_req.y       = 19'(r_cx);
        cor_req.x       = r_ncz;
        unique case (r_state)
            tep_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = tep_pkg::ST_PREP;
                end
            end
            tep_pkg::ST_PREP: n_state = tep_pkg::ST_CY_GO;
            tep_pkg::ST_CY_GO: begin
                cor_req.start = 1'b1;
                n_state       = tep_pkg::ST_CY_WAIT;
            end
            tep_pkg::ST_CY_WAIT: begin
                if (cor_rsp.done) begin
                    n_state = tep_pkg::ST_CX_GO;
                end
            end
            tep_pkg::ST_CX_GO: begin
                cor_req.start = 1'b1;
                cor_req.y     = 19'(r_cy);
                n_state       = tep_pkg::ST_CX_WAIT;
            end
            tep_pkg::ST_CX_WAIT: begin
                if (cor_rsp.done) begin
                    n_state = tep_pkg::ST_MUL;
                end
            end
            tep_pkg::ST_MUL: begin
                if (r_k == 2'd3) begin
                    n_state = tep_pkg::ST_POST;
                end
            end
            tep_pkg::ST_POST: n_state = tep_pkg::ST_DONE;
            tep_pkg::ST_DONE: begin
                if (!r_o_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = tep_pkg::ST_IDLE;
                end
            end
            default: n_state = tep_pkg::ST_IDLE;
        endcase
    end

    assign o_ready = (r_state == tep_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tilt_x  <= '0;
            r_tilt_y  <= '0;
            r_posture <= tep_pkg::POS_UNKNOWN;
            r_k       <= '0;
        end else begin
            case (r_state)
                tep_pkg::ST_IDLE: begin
                    r_ax <= i_accel_x;
                    r_ay <= i_accel_y;
                    r_az <= i_accel_z;
                    r_gx <= i_rate_x;
                    r_gy <= i_rate_y;
                    r_k  <= '0;
                end
                tep_pkg::ST_PREP: begin
                    r_abs_ax <= abs_ax;
                    r_cx     <= 17'(r_ax) - 17'(sel_off_x);
                    r_cy     <= 17'(r_ay) - 17'(sel_off_y);
                    r_ncz    <= -19'(cz);
                    r_tilt_x <= tep_pkg::sat_ang(44'(int_x));
                    r_tilt_y <= tep_pkg::sat_ang(44'(int_y));
                end
                tep_pkg::ST_CY_WAIT: begin
                    if (cor_rsp.done) begin
                        r_acc_y <= cor_rsp.angle;
                    end
                end
                tep_pkg::ST_CX_WAIT: begin
                    if (cor_rsp.done) begin
                        r_acc_x <= -cor_rsp.angle;
                    end
                end
                tep_pkg::ST_MUL: begin
                    r_k <= r_k + 2'd1;
                    if (!r_k[0]) begin
                        r_accum <= sum;
                    end else if (r_k[1]) begin
                        r_tilt_x <= tep_pkg::sat_ang(sum >>> 16);
                    end else begin
                        r_tilt_y <= tep_pkg::sat_ang(sum >>> 16);
                    end
                end
                tep_pkg::ST_POST: begin
                    unique case (r_posture) inside
                        tep_pkg::POS_UNKNOWN, tep_pkg::POS_NONE: begin
                            if (vert_ok || edge_ok) begin
                                r_tilt_x  <= r_acc_x;
                                r_tilt_y  <= r_acc_y;
                                r_posture <= vert_ok ? tep_pkg::POS_VERTEX
                                                     : tep_pkg::POS_EDGE;
                            end else begin
                                r_posture <= tep_pkg::POS_NONE;
                            end
                        end
                        default: begin
                            if (tep_pkg::ang_abs(r_tilt_x) > tep_pkg::FALL_TILT_LIM
                                || tep_pkg::ang_abs(r_tilt_y) > tep_pkg::FALL_TILT_LIM) begin
                                r_posture <= tep_pkg::POS_NONE;
                            end
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_tilt_x_out <= tep_pkg::out_ang(r_tilt_x);
            o_tilt_y_out <= tep_pkg::out_ang(r_tilt_y);
            o_acc_tilt_x <= tep_pkg::out_ang(r_acc_x);
            o_acc_tilt_y <= tep_pkg::out_ang(r_acc_y);
            o_posture    <= r_posture;
        end
    end

    assign o_valid = r_o_valid;

    `TEP_ASSERT_IMP(a_cor_done_in_wait, i_clk, i_rst_n, cor_rsp.done, (r_state == tep_pkg::ST_CY_WAIT || r_state == tep_pkg::ST_CX_WAIT), "cordic done outside a wait state")
    `TEP_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, (i_valid && o_ready), (!o_ready), "input ready right after accepting a word")
    `TEP_ASSERT_IMP(a_tilt_in_range, i_clk, i_rst_n, o_valid, (o_tilt_x_out <= 17'sd46080 && o_tilt_x_out >= -17'sd46080), "fused tilt out of range")

endmodule
